// ----- src/pvc_pkg.sv -----
// Package for the priority vector clip core: widths, pipeline lane types and
// the per-stage step functions for square root and division.
// No dependencies; used by src/priority_vector_clip_core.sv.
package pvc_pkg;

  localparam int COMP_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int MAG_W       = COMP_W - 1;
  localparam int SUM_W       = 2 * COMP_W;
  localparam int ROOT_W      = COMP_W;
  localparam int SQRT_REM_W  = COMP_W + 4;
  localparam int DIV_REM_W   = COMP_W + 1;
  localparam int PROD_W      = COMP_W + MAG_W;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_STAGES  = COMP_W;

  // Budget after reset: 1.0 in the component format
  localparam logic [MAG_W-1:0] MAX_RESET = MAG_W'(64'd1 << FRAC_W);

  typedef logic [COMP_W-1:0] comp_t;

  localparam comp_t COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};
  localparam comp_t COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};

  typedef struct packed {
    comp_t [2:0] a;
    comp_t [2:0] b;
  } pair_t;

  typedef struct packed {
    logic [SUM_W-1:0]      rad;
    logic [SQRT_REM_W-1:0] rem;
    logic [ROOT_W-1:0]     root;
  } sqrt_lane_t;

  typedef struct packed {
    logic [COMP_W-1:0]    num_lo;
    logic [DIV_REM_W-1:0] rem;
    logic [COMP_W-1:0]    quo;
  } div_lane_t;

  typedef enum logic [1:0] {
    MODE_CLIP_FIRST,
    MODE_PASS_BOTH,
    MODE_CLIP_SECOND
  } clip_mode_t;

  typedef struct packed {
    clip_mode_t mode;
    logic       zero_first;
    logic [2:0] neg;
  } clip_ctl_t;

  // One result bit of the digit-by-digit square root
  function automatic sqrt_lane_t sqrt_step(sqrt_lane_t s);
    logic [SQRT_REM_W-1:0] rem2;
    logic [SQRT_REM_W-1:0] trial;
    sqrt_lane_t o;
    rem2  = {s.rem[SQRT_REM_W-3:0], s.rad[SUM_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    o.rad = s.rad << 2;
    if (rem2 >= trial) begin
      o.rem  = rem2 - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rem2;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // One quotient bit of restoring division
  function automatic div_lane_t div_step(div_lane_t s, logic [COMP_W-1:0] d);
    logic [DIV_REM_W-1:0] rem2;
    div_lane_t o;
    rem2     = {s.rem[COMP_W-1:0], s.num_lo[COMP_W-1]};
    o.num_lo = s.num_lo << 1;
    if (rem2 >= {1'b0, d}) begin
      o.rem = rem2 - {1'b0, d};
      o.quo = {s.quo[COMP_W-2:0], 1'b1};
    end else begin
      o.rem = rem2;
      o.quo = {s.quo[COMP_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic comp_t abs_comp(comp_t c);
    return c[COMP_W-1] ? (~c + 1'b1) : c;
  endfunction

  // Apply sign to an unsigned magnitude and clamp to the signed range
  function automatic comp_t sat_signed(logic neg, comp_t q);
    comp_t m;
    if (neg) begin
      m = (q > COMP_MIN) ? COMP_MIN : q;
      return ~m + 1'b1;
    end else begin
      m = (q > COMP_MAX) ? COMP_MAX : q;
      return m;
    end
  endfunction

  function automatic comp_t sat_add(comp_t x, comp_t y);
    logic [COMP_W:0] s;
    s = {x[COMP_W-1], x} + {y[COMP_W-1], y};
    if (s[COMP_W] != s[COMP_W-1]) begin
      return s[COMP_W] ? COMP_MIN : COMP_MAX;
    end
    return s[COMP_W-1:0];
  endfunction

endpackage

// ----- src/priority_vector_clip_core.sv -----
// Priority vector clip core: magnitude budget split between two 3-D vectors.
// Depends on src/pvc_pkg.sv for widths, lane types and step functions.
//
// Usage:
//   Request channel: drive the six components and pulse start; a request is
//   taken at every rising edge with start high and busy low. busy is high
//   only during reset, so a new request can enter every cycle.
//   Result channel: done is high for one cycle with the clipped first and
//   second vectors and their saturated sum. The receiver cannot stall; each
//   result is on the ports for exactly that cycle.
//   Budget: write max_magnitude (unsigned Q15.16) through cfg_valid/cfg_data;
//   cfg_ready is always high. Write it only while no request is in flight.
// Pipeline: input, square and sum registers, square root, decision,
//   multiply, divider, clip and result registers. Throughput: one request
//   per cycle, set by the fully pipelined 32-stage square root (one root
//   bit per stage) and 32-stage divider (one quotient bit per stage).
// Reset: synchronous, clears every stage valid bit and the result strobe,
//   and sets the budget to 1.0. Requests in flight are dropped.
module priority_vector_clip_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [pvc_pkg::COMP_W-1:0] first_x,
  input  logic signed [pvc_pkg::COMP_W-1:0] first_y,
  input  logic signed [pvc_pkg::COMP_W-1:0] first_z,
  input  logic signed [pvc_pkg::COMP_W-1:0] second_x,
  input  logic signed [pvc_pkg::COMP_W-1:0] second_y,
  input  logic signed [pvc_pkg::COMP_W-1:0] second_z,
  output logic                         done,
  output logic signed [pvc_pkg::COMP_W-1:0] clipped_first_x,
  output logic signed [pvc_pkg::COMP_W-1:0] clipped_first_y,
  output logic signed [pvc_pkg::COMP_W-1:0] clipped_first_z,
  output logic signed [pvc_pkg::COMP_W-1:0] clipped_second_x,
  output logic signed [pvc_pkg::COMP_W-1:0] clipped_second_y,
  output logic signed [pvc_pkg::COMP_W-1:0] clipped_second_z,
  output logic signed [pvc_pkg::COMP_W-1:0] total_x,
  output logic signed [pvc_pkg::COMP_W-1:0] total_y,
  output logic signed [pvc_pkg::COMP_W-1:0] total_z,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pvc_pkg::MAG_W-1:0]    cfg_data
);

  logic [pvc_pkg::MAG_W-1:0] max_mag;

  // Input stage
  logic           in_v;
  pvc_pkg::pair_t in_it;
  // Square stage
  logic               sqr_v;
  pvc_pkg::pair_t     sqr_it;
  logic [pvc_pkg::SUM_W-1:0] sqr_a [3];
  logic [pvc_pkg::SUM_W-1:0] sqr_b [3];
  // Square root pipeline, entry 0 holds the sums of squares
  logic                   sq_v  [pvc_pkg::SQRT_STAGES+1];
  pvc_pkg::pair_t         sq_it [pvc_pkg::SQRT_STAGES+1];
  pvc_pkg::sqrt_lane_t    sq_la [pvc_pkg::SQRT_STAGES+1];
  pvc_pkg::sqrt_lane_t    sq_lb [pvc_pkg::SQRT_STAGES+1];
  // Decision stage
  logic                      dc_v;
  pvc_pkg::pair_t            dc_it;
  pvc_pkg::clip_ctl_t        dc_ctl;
  pvc_pkg::comp_t            dc_abs [3];
  logic [pvc_pkg::COMP_W-1:0] dc_len;
  logic [pvc_pkg::MAG_W-1:0]  dc_t;
  // Multiply stage
  logic                       mu_v;
  pvc_pkg::pair_t             mu_it;
  pvc_pkg::clip_ctl_t         mu_ctl;
  logic [pvc_pkg::PROD_W-1:0] mu_p [3];
  logic [pvc_pkg::COMP_W-1:0] mu_len;
  // Divider pipeline, entry 0 holds the rounded numerators
  logic                       dv_v   [pvc_pkg::DIV_STAGES+1];
  pvc_pkg::pair_t             dv_it  [pvc_pkg::DIV_STAGES+1];
  pvc_pkg::clip_ctl_t         dv_ctl [pvc_pkg::DIV_STAGES+1];
  logic [pvc_pkg::COMP_W-1:0] dv_d   [pvc_pkg::DIV_STAGES+1];
  pvc_pkg::div_lane_t         dv_l   [pvc_pkg::DIV_STAGES+1][3];
  // Clip stage
  logic           cl_v;
  pvc_pkg::comp_t cl_a [3];
  pvc_pkg::comp_t cl_b [3];

  logic [pvc_pkg::SUM_W-1:0] num [3];

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  // Budget register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_mag <= pvc_pkg::MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_mag <= cfg_data;
    end
  end

  // Capture request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= start && !busy;
    end
    in_it.a <= {first_z, first_y, first_x};
    in_it.b <= {second_z, second_y, second_x};
  end

  // Square the absolute components
  always_ff @(posedge clk) begin
    if (rst) begin
      sqr_v <= 1'b0;
    end else begin
      sqr_v <= in_v;
    end
    sqr_it <= in_it;
    for (int i = 0; i < 3; i++) begin
      sqr_a[i] <= pvc_pkg::SUM_W'(pvc_pkg::abs_comp(in_it.a[i]))
                * pvc_pkg::SUM_W'(pvc_pkg::abs_comp(in_it.a[i]));
      sqr_b[i] <= pvc_pkg::SUM_W'(pvc_pkg::abs_comp(in_it.b[i]))
                * pvc_pkg::SUM_W'(pvc_pkg::abs_comp(in_it.b[i]));
    end
  end

  // Sum the squares and seed the root lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else begin
      sq_v[0] <= sqr_v;
    end
    sq_it[0]      <= sqr_it;
    sq_la[0].rad  <= sqr_a[0] + sqr_a[1] + sqr_a[2];
    sq_la[0].rem  <= '0;
    sq_la[0].root <= '0;
    sq_lb[0].rad  <= sqr_b[0] + sqr_b[1] + sqr_b[2];
    sq_lb[0].rem  <= '0;
    sq_lb[0].root <= '0;
  end

  // Advance the root one bit per stage
  for (genvar k = 0; k < pvc_pkg::SQRT_STAGES; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else begin
        sq_v[k+1] <= sq_v[k];
      end
      sq_it[k+1] <= sq_it[k];
      sq_la[k+1] <= pvc_pkg::sqrt_step(sq_la[k]);
      sq_lb[k+1] <= pvc_pkg::sqrt_step(sq_lb[k]);
    end
  end

  // Pick the branch, the vector to rescale, its length and target
  logic [pvc_pkg::COMP_W-1:0] m1, m2;
  logic                       over_budget, fits_budget;
  pvc_pkg::clip_ctl_t         ctl_next;
  pvc_pkg::comp_t             sel [3];
  logic [pvc_pkg::COMP_W-1:0] len_next;
  logic [pvc_pkg::MAG_W-1:0]  t_next;

  always_comb begin
    m1          = sq_la[pvc_pkg::SQRT_STAGES].root;
    m2          = sq_lb[pvc_pkg::SQRT_STAGES].root;
    over_budget = m1 >= {1'b0, max_mag};
    fits_budget = ({1'b0, m1} + {1'b0, m2}) < {2'b00, max_mag};
    ctl_next.zero_first = (m1 == '0);
    if (over_budget) begin
      ctl_next.mode = pvc_pkg::MODE_CLIP_FIRST;
      len_next      = m1;
      t_next        = max_mag;
    end else begin
      ctl_next.mode = fits_budget ? pvc_pkg::MODE_PASS_BOTH : pvc_pkg::MODE_CLIP_SECOND;
      len_next      = m2;
      t_next        = max_mag - m1[pvc_pkg::MAG_W-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      sel[i] = over_budget ? sq_it[pvc_pkg::SQRT_STAGES].a[i]
                           : sq_it[pvc_pkg::SQRT_STAGES].b[i];
      ctl_next.neg[i] = sel[i][pvc_pkg::COMP_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dc_v <= 1'b0;
    end else begin
      dc_v <= sq_v[pvc_pkg::SQRT_STAGES];
    end
    dc_it  <= sq_it[pvc_pkg::SQRT_STAGES];
    dc_ctl <= ctl_next;
    dc_len <= len_next;
    dc_t   <= t_next;
    for (int i = 0; i < 3; i++) begin
      dc_abs[i] <= pvc_pkg::abs_comp(sel[i]);
    end
  end

  // Scale magnitudes by the target length
  always_ff @(posedge clk) begin
    if (rst) begin
      mu_v <= 1'b0;
    end else begin
      mu_v <= dc_v;
    end
    mu_it  <= dc_it;
    mu_ctl <= dc_ctl;
    mu_len <= dc_len;
    for (int i = 0; i < 3; i++) begin
      mu_p[i] <= pvc_pkg::PROD_W'(dc_abs[i]) * pvc_pkg::PROD_W'(dc_t);
    end
  end

  // Add half the divisor for round-to-nearest, seed the divider lanes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, mu_p[i]} + pvc_pkg::SUM_W'(mu_len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else begin
      dv_v[0] <= mu_v;
    end
    dv_it[0]  <= mu_it;
    dv_ctl[0] <= mu_ctl;
    dv_d[0]   <= mu_len;
    for (int i = 0; i < 3; i++) begin
      dv_l[0][i].num_lo <= num[i][pvc_pkg::COMP_W-1:0];
      dv_l[0][i].rem    <= {1'b0, num[i][pvc_pkg::SUM_W-1:pvc_pkg::COMP_W]};
      dv_l[0][i].quo    <= '0;
    end
  end

  // Advance the quotients one bit per stage
  for (genvar j = 0; j < pvc_pkg::DIV_STAGES; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else begin
        dv_v[j+1] <= dv_v[j];
      end
      dv_it[j+1]  <= dv_it[j];
      dv_ctl[j+1] <= dv_ctl[j];
      dv_d[j+1]   <= dv_d[j];
      for (int i = 0; i < 3; i++) begin
        dv_l[j+1][i] <= pvc_pkg::div_step(dv_l[j][i], dv_d[j]);
      end
    end
  end

  // Assemble the clipped vectors
  pvc_pkg::clip_ctl_t dctl;
  pvc_pkg::pair_t     dit;
  pvc_pkg::comp_t     scaled [3];
  pvc_pkg::comp_t     cla_next [3];
  pvc_pkg::comp_t     clb_next [3];

  always_comb begin
    dctl = dv_ctl[pvc_pkg::DIV_STAGES];
    dit  = dv_it[pvc_pkg::DIV_STAGES];
    for (int i = 0; i < 3; i++) begin
      scaled[i] = pvc_pkg::sat_signed(dctl.neg[i], dv_l[pvc_pkg::DIV_STAGES][i].quo);
      unique case (dctl.mode)
        pvc_pkg::MODE_CLIP_FIRST: begin
          cla_next[i] = dctl.zero_first ? '0 : scaled[i];
          clb_next[i] = '0;
        end
        pvc_pkg::MODE_PASS_BOTH: begin
          cla_next[i] = dit.a[i];
          clb_next[i] = dit.b[i];
        end
        pvc_pkg::MODE_CLIP_SECOND: begin
          cla_next[i] = dit.a[i];
          clb_next[i] = scaled[i];
        end
        default: begin
          cla_next[i] = '0;
          clb_next[i] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cl_v <= 1'b0;
    end else begin
      cl_v <= dv_v[pvc_pkg::DIV_STAGES];
    end
    for (int i = 0; i < 3; i++) begin
      cl_a[i] <= cla_next[i];
      cl_b[i] <= clb_next[i];
    end
  end

  // Result register with saturated sums
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cl_v;
    end
    clipped_first_x  <= cl_a[0];
    clipped_first_y  <= cl_a[1];
    clipped_first_z  <= cl_a[2];
    clipped_second_x <= cl_b[0];
    clipped_second_y <= cl_b[1];
    clipped_second_z <= cl_b[2];
    total_x          <= pvc_pkg::sat_add(cl_a[0], cl_b[0]);
    total_y          <= pvc_pkg::sat_add(cl_a[1], cl_b[1]);
    total_z          <= pvc_pkg::sat_add(cl_a[2], cl_b[2]);
  end

endmodule

// ----- src/pvc_checker.sv -----
// Port-level checker for the priority vector clip core, with its bind.
// Depends on src/pvc_pkg.sv and src/priority_vector_clip_core.sv.
module pvc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         busy,
  input logic                         done,
  input logic [pvc_pkg::COMP_W-1:0]   clipped_first_x,
  input logic [pvc_pkg::COMP_W-1:0]   clipped_first_y,
  input logic [pvc_pkg::COMP_W-1:0]   clipped_first_z,
  input logic [pvc_pkg::COMP_W-1:0]   clipped_second_x,
  input logic [pvc_pkg::COMP_W-1:0]   clipped_second_y,
  input logic [pvc_pkg::COMP_W-1:0]   clipped_second_z,
  input logic [pvc_pkg::COMP_W-1:0]   total_x,
  input logic [pvc_pkg::COMP_W-1:0]   total_y,
  input logic [pvc_pkg::COMP_W-1:0]   total_z
);

  logic [pvc_pkg::COMP_W:0] sum_x, sum_y, sum_z;

  // Sign-extended sums of the clipped vectors
  assign sum_x = {clipped_first_x[pvc_pkg::COMP_W-1], clipped_first_x}
               + {clipped_second_x[pvc_pkg::COMP_W-1], clipped_second_x};
  assign sum_y = {clipped_first_y[pvc_pkg::COMP_W-1], clipped_first_y}
               + {clipped_second_y[pvc_pkg::COMP_W-1], clipped_second_y};
  assign sum_z = {clipped_first_z[pvc_pkg::COMP_W-1], clipped_first_z}
               + {clipped_second_z[pvc_pkg::COMP_W-1], clipped_second_z};

  a_reset_clears_done: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_never_busy: assert property (@(posedge clk) !rst |-> !busy)
    else $error("busy outside reset");

  a_total_x: assert property (@(posedge clk) disable iff (rst)
    done && (sum_x[pvc_pkg::COMP_W] == sum_x[pvc_pkg::COMP_W-1])
      |-> total_x == sum_x[pvc_pkg::COMP_W-1:0])
    else $error("total_x differs from clipped sum");

  a_total_y: assert property (@(posedge clk) disable iff (rst)
    done && (sum_y[pvc_pkg::COMP_W] == sum_y[pvc_pkg::COMP_W-1])
      |-> total_y == sum_y[pvc_pkg::COMP_W-1:0])
    else $error("total_y differs from clipped sum");

  a_total_z: assert property (@(posedge clk) disable iff (rst)
    done && (sum_z[pvc_pkg::COMP_W] == sum_z[pvc_pkg::COMP_W-1])
      |-> total_z == sum_z[pvc_pkg::COMP_W-1:0])
    else $error("total_z differs from clipped sum");

endmodule

bind priority_vector_clip_core pvc_checker u_pvc_checker (.*);
